@@ sv/phcl_pkg.sv @@
// Shared types, constants and hash helpers for the perfect hash category lookup.
// Holds the payload structs of both channels, command and status codes, the FNV step
// and the per-byte remainder step. Depends on nothing.
package phcl_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int LEN_W       = 9;
	localparam int HASH_W      = 32;
	localparam int KEY_BYTES   = 8;
	localparam int DATA_W      = 64;
	localparam int STEP_BITS   = 8;
	localparam int MOD_STAGES  = HASH_W / STEP_BITS;
	localparam int REG_IDX_W   = 1;

	localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;

	localparam logic [2:0] CMD_WR_DISP  = 3'd0;
	localparam logic [2:0] CMD_WR_SLOT  = 3'd1;
	localparam logic [2:0] CMD_WR_KEY   = 3'd2;
	localparam logic [2:0] CMD_WR_VALUE = 3'd3;
	localparam logic [2:0] CMD_LOOKUP   = 3'd4;

	localparam logic [1:0] ST_FOUND    = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_TABLE_LEN = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_DEFAULT   = 1'b1;

	typedef struct packed {
		logic [2:0]              cmd;
		logic [7:0]              table_slot;
		logic signed [DATA_W-1:0] table_word;
		logic signed [DATA_W-1:0] lookup_key;
	} item_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [7:0]              slot_index;
		logic signed [DATA_W-1:0] mapped_value;
	} result_t;

	// what every stage carries: the key for a lookup, the entry data for a write
	typedef struct packed {
		logic [2:0]        cmd;
		logic [7:0]        slot;
		logic [DATA_W-1:0] data;
	} carry_t;

	// outcome of the displacement read, carried alongside the second hash
	typedef struct packed {
		logic              neg;
		logic              oor;
		logic [ADDR_W-1:0] pick;
	} disp_info_t;

	function automatic logic [HASH_W-1:0] hash_step(logic [HASH_W-1:0] h, logic [7:0] b);
		logic [HASH_W-1:0] p;
		p = h * FNV_PRIME;
		return p ^ {{(HASH_W-8){b[7]}}, b};
	endfunction

	// shift eight dividend bits into the remainder, MSB first; r stays below n
	function automatic logic [LEN_W-1:0] mod_byte(logic [LEN_W-1:0] r, logic [7:0] b,
			logic [LEN_W-1:0] n);
		logic [LEN_W:0]   t;
		logic [LEN_W-1:0] acc;
		acc = r;
		for (int i = STEP_BITS - 1; i >= 0; i--) begin
			t = {acc, b[i]};
			if (t >= {1'b0, n}) begin
				t = t - {1'b0, n};
			end
			acc = t[LEN_W-1:0];
		end
		return acc;
	endfunction

	function automatic logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] v);
		if (v == '0) begin
			return LEN_W'(1);
		end else if (v > LEN_W'(TABLE_DEPTH)) begin
			return LEN_W'(TABLE_DEPTH);
		end
		return v;
	endfunction

endpackage

@@ sv/perfect_hash_category_lookup_unit.sv @@
// Top level of the perfect hash category lookup: hash pipeline, table memories, output register.
// Depends on phcl_pkg for payload types, codes and the hash and remainder steps.
//
// Usage:
// - item channel (item_valid/item_ready/item): commands 0 to 3 load the displacement,
//   slot, key and value tables at item.table_slot; command 4 looks up item.lookup_key.
//   Commands 5 to 7 are dropped.
// - result channel (result_valid/result_ready/result): one transfer per lookup, none
//   for any other command, in the order the items were taken.
// - cfg_we/cfg_index/cfg_wdata: index 0 sets table_len (0 reads as 1, above 256 as 256),
//   index 1 sets default_value. Write only while no lookup is in flight.
// Throughput: one item per cycle while no waiting result stalls the pipeline.
// Each FNV byte step takes one stage and each eight-bit slice of the modulo takes one
// stage; the two hashes, two remainders, three registered table reads and the output register make the depth.
// Table writes take effect at the stage that reads that table, so every lookup sees
// exactly the writes taken before it.
// Reset empties the pipeline and sets table_len to 1 and default_value to 0; the tables
// are not cleared and must be loaded before use.
// While a result waits and result_ready is low, the whole pipeline holds and item_ready
// drops; nothing is lost or repeated.
module perfect_hash_category_lookup_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  phcl_pkg::item_t                       item,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output phcl_pkg::result_t                     result,
	input  logic                                  cfg_we,
	input  logic [phcl_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [phcl_pkg::DATA_W-1:0]           cfg_wdata
);

	localparam int H = phcl_pkg::KEY_BYTES;
	localparam int M = phcl_pkg::MOD_STAGES;

	logic                           adv;
	logic [phcl_pkg::LEN_W-1:0]     len_q;
	logic [phcl_pkg::DATA_W-1:0]    default_q;
	phcl_pkg::carry_t               intake;

	// first hash and its remainder
	logic                           v1_s [H];
	phcl_pkg::carry_t               c1_s [H];
	logic [phcl_pkg::HASH_W-1:0]    h1_s [H];
	logic                           v2_s [M];
	phcl_pkg::carry_t               c2_s [M];
	logic [phcl_pkg::LEN_W-1:0]     r2_s [M];
	logic [phcl_pkg::HASH_W-1:0]    hm2_s [M-1];

	// displacement read
	logic                           vd_s;
	phcl_pkg::carry_t               cd_s;
	logic [phcl_pkg::HASH_W-1:0]    disp_s;
	phcl_pkg::disp_info_t           dinfo;
	logic [phcl_pkg::HASH_W-1:0]    seed;
	logic [phcl_pkg::HASH_W-1:0]    pick_full;

	// second hash and its remainder
	logic                           v3_s [H];
	phcl_pkg::carry_t               c3_s [H];
	logic [phcl_pkg::HASH_W-1:0]    h3_s [H];
	phcl_pkg::disp_info_t           n3_s [H];
	logic                           v4_s [M];
	phcl_pkg::carry_t               c4_s [M];
	logic [phcl_pkg::LEN_W-1:0]     r4_s [M];
	logic [phcl_pkg::HASH_W-1:0]    hm4_s [M-1];
	phcl_pkg::disp_info_t           n4_s [M];

	// slot read, key and value read
	logic [phcl_pkg::ADDR_W-1:0]    slot_addr;
	logic                           vs_s;
	phcl_pkg::carry_t               cs_s;
	logic                           oors_s;
	logic [phcl_pkg::HASH_W-1:0]    slot_s;
	logic                           vk_s;
	phcl_pkg::carry_t               ck_s;
	logic                           oork_s;
	logic [phcl_pkg::ADDR_W-1:0]    idx_s;
	logic [phcl_pkg::DATA_W-1:0]    key_s;
	logic [phcl_pkg::DATA_W-1:0]    val_s;

	logic                           result_valid_q;
	phcl_pkg::result_t              result_q;
	phcl_pkg::result_t              result_next;

	logic [phcl_pkg::HASH_W-1:0]    disp_mem [phcl_pkg::TABLE_DEPTH];
	logic [phcl_pkg::HASH_W-1:0]    slot_mem [phcl_pkg::TABLE_DEPTH];
	logic [phcl_pkg::DATA_W-1:0]    key_mem  [phcl_pkg::TABLE_DEPTH];
	logic [phcl_pkg::DATA_W-1:0]    val_mem  [phcl_pkg::TABLE_DEPTH];

	assign adv          = !result_valid_q || result_ready;
	assign item_ready   = adv;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign intake.cmd  = item.cmd;
	assign intake.slot = item.table_slot;
	assign intake.data = (item.cmd == phcl_pkg::CMD_LOOKUP) ? item.lookup_key : item.table_word;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= phcl_pkg::LEN_W'(1);
			default_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				phcl_pkg::REG_TABLE_LEN: len_q <= phcl_pkg::clamp_len(cfg_wdata[phcl_pkg::LEN_W-1:0]);
				phcl_pkg::REG_DEFAULT:   default_q <= cfg_wdata;
				default:                 default_q <= default_q;
			endcase
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s           <= '{default: 1'b0};
			v2_s           <= '{default: 1'b0};
			vd_s           <= 1'b0;
			v3_s           <= '{default: 1'b0};
			v4_s           <= '{default: 1'b0};
			vs_s           <= 1'b0;
			vk_s           <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			v1_s[0] <= item_valid;
			for (int k = 1; k < H; k++) begin
				v1_s[k] <= v1_s[k-1];
			end
			v2_s[0] <= v1_s[H-1];
			for (int j = 1; j < M; j++) begin
				v2_s[j] <= v2_s[j-1];
			end
			vd_s    <= v2_s[M-1];
			v3_s[0] <= vd_s;
			for (int k = 1; k < H; k++) begin
				v3_s[k] <= v3_s[k-1];
			end
			v4_s[0] <= v3_s[H-1];
			for (int j = 1; j < M; j++) begin
				v4_s[j] <= v4_s[j-1];
			end
			vs_s           <= v4_s[M-1];
			vk_s           <= vs_s;
			result_valid_q <= vk_s && (ck_s.cmd == phcl_pkg::CMD_LOOKUP);
		end
	end

	// displacement decode: a negative entry names the slot entry directly
	always_comb begin
		pick_full  = ~disp_s;
		dinfo.neg  = disp_s[phcl_pkg::HASH_W-1];
		dinfo.oor  = disp_s[phcl_pkg::HASH_W-1] && (pick_full >= phcl_pkg::HASH_W'(len_q));
		dinfo.pick = pick_full[phcl_pkg::ADDR_W-1:0];
		seed       = (disp_s == '0) ? phcl_pkg::FNV_PRIME : disp_s;
	end

	// hash and remainder datapath
	always_ff @(posedge clk) begin
		if (adv) begin
			c1_s[0] <= intake;
			h1_s[0] <= phcl_pkg::hash_step(phcl_pkg::FNV_PRIME, intake.data[7:0]);
			for (int k = 1; k < H; k++) begin
				c1_s[k] <= c1_s[k-1];
				h1_s[k] <= phcl_pkg::hash_step(h1_s[k-1], c1_s[k-1].data[8*k +: 8]);
			end

			c2_s[0]  <= c1_s[H-1];
			r2_s[0]  <= phcl_pkg::mod_byte('0, h1_s[H-1][phcl_pkg::HASH_W-1 -: 8], len_q);
			hm2_s[0] <= h1_s[H-1] << phcl_pkg::STEP_BITS;
			for (int j = 1; j < M; j++) begin
				c2_s[j] <= c2_s[j-1];
				r2_s[j] <= phcl_pkg::mod_byte(r2_s[j-1], hm2_s[j-1][phcl_pkg::HASH_W-1 -: 8], len_q);
			end
			for (int j = 1; j < M - 1; j++) begin
				hm2_s[j] <= hm2_s[j-1] << phcl_pkg::STEP_BITS;
			end

			cd_s <= c2_s[M-1];

			c3_s[0] <= cd_s;
			h3_s[0] <= phcl_pkg::hash_step(seed, cd_s.data[7:0]);
			n3_s[0] <= dinfo;
			for (int k = 1; k < H; k++) begin
				c3_s[k] <= c3_s[k-1];
				h3_s[k] <= phcl_pkg::hash_step(h3_s[k-1], c3_s[k-1].data[8*k +: 8]);
				n3_s[k] <= n3_s[k-1];
			end

			c4_s[0]  <= c3_s[H-1];
			r4_s[0]  <= phcl_pkg::mod_byte('0, h3_s[H-1][phcl_pkg::HASH_W-1 -: 8], len_q);
			hm4_s[0] <= h3_s[H-1] << phcl_pkg::STEP_BITS;
			n4_s[0]  <= n3_s[H-1];
			for (int j = 1; j < M; j++) begin
				c4_s[j] <= c4_s[j-1];
				r4_s[j] <= phcl_pkg::mod_byte(r4_s[j-1], hm4_s[j-1][phcl_pkg::HASH_W-1 -: 8], len_q);
				n4_s[j] <= n4_s[j-1];
			end
			for (int j = 1; j < M - 1; j++) begin
				hm4_s[j] <= hm4_s[j-1] << phcl_pkg::STEP_BITS;
			end

			cs_s   <= c4_s[M-1];
			oors_s <= n4_s[M-1].oor;

			ck_s   <= cs_s;
			oork_s <= oors_s || (slot_s >= phcl_pkg::HASH_W'(len_q));
			idx_s  <= slot_s[phcl_pkg::ADDR_W-1:0];
		end
	end

	// displacement table: written and read at the end of the first remainder
	always_ff @(posedge clk) begin
		if (adv) begin
			if (v2_s[M-1] && c2_s[M-1].cmd == phcl_pkg::CMD_WR_DISP) begin
				disp_mem[c2_s[M-1].slot] <= c2_s[M-1].data[phcl_pkg::HASH_W-1:0];
			end
			disp_s <= disp_mem[r2_s[M-1][phcl_pkg::ADDR_W-1:0]];
		end
	end

	assign slot_addr = n4_s[M-1].neg ? n4_s[M-1].pick : r4_s[M-1][phcl_pkg::ADDR_W-1:0];

	// slot table: written and read at the end of the second remainder
	always_ff @(posedge clk) begin
		if (adv) begin
			if (v4_s[M-1] && c4_s[M-1].cmd == phcl_pkg::CMD_WR_SLOT) begin
				slot_mem[c4_s[M-1].slot] <= c4_s[M-1].data[phcl_pkg::HASH_W-1:0];
			end
			slot_s <= slot_mem[slot_addr];
		end
	end

	// key and value tables share the slot read result as address
	always_ff @(posedge clk) begin
		if (adv) begin
			if (vs_s && cs_s.cmd == phcl_pkg::CMD_WR_KEY) begin
				key_mem[cs_s.slot] <= cs_s.data;
			end
			key_s <= key_mem[slot_s[phcl_pkg::ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (vs_s && cs_s.cmd == phcl_pkg::CMD_WR_VALUE) begin
				val_mem[cs_s.slot] <= cs_s.data;
			end
			val_s <= val_mem[slot_s[phcl_pkg::ADDR_W-1:0]];
		end
	end

	always_comb begin
		priority if (oork_s) begin
			result_next.status       = phcl_pkg::ST_RANGE;
			result_next.slot_index   = '0;
			result_next.mapped_value = default_q;
		end else if (key_s == ck_s.data) begin
			result_next.status       = phcl_pkg::ST_FOUND;
			result_next.slot_index   = idx_s;
			result_next.mapped_value = val_s;
		end else begin
			result_next.status       = phcl_pkg::ST_MISMATCH;
			result_next.slot_index   = idx_s;
			result_next.mapped_value = default_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= result_next;
		end
	end

	// a lookup leaving the last stage always becomes a result
	a_lookup_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vk_s && ck_s.cmd == phcl_pkg::CMD_LOOKUP |=> result_valid_q)
		else $error("lookup left the pipeline without a result");

	// table writes and unused commands never produce a result
	a_write_gives_none: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vk_s && ck_s.cmd != phcl_pkg::CMD_LOOKUP |=> !result_valid_q)
		else $error("non-lookup command produced a result");

	// a blocked result freezes the pipeline
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_ready |=> $stable(v1_s[0]) && $stable(vd_s) && $stable(vk_s))
		else $error("pipeline moved while the result was stalled");

	// an out-of-range slot reports slot index zero
	a_range_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.status == phcl_pkg::ST_RANGE |-> result_q.slot_index == '0)
		else $error("out-of-range result carries a nonzero slot index");

endmodule

@@ test/perfect_hash_category_lookup_unit_tb.sv @@
// Testbench for perfect_hash_category_lookup_unit: table loads, lookups and register writes
// checked against a predictor of the hash-and-displace lookup kept in this file.
// Depends on phcl_pkg (sv/phcl_pkg.sv) and the unit under test.
module perfect_hash_category_lookup_unit_tb;

	localparam int CYCLE_LIMIT     = 500000;
	localparam int DRAIN_CYCLES    = 40;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int N_PHASES        = 10;
	localparam int N_DIRECTED      = 25;
	localparam logic [2:0] CMD_SPARE_FIRST = phcl_pkg::CMD_LOOKUP + 3'd1;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

	localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [2:0]  cmd;
		logic [7:0]  slot;
		logic [63:0] word;
		logic [63:0] key;
		bit          typed;
		logic [1:0]  st;
		logic [7:0]  idx;
		logic [63:0] val;
	} step_row_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_ready;
	phcl_pkg::item_t   item         = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	phcl_pkg::result_t result;
	logic              cfg_we       = 1'b0;
	logic [phcl_pkg::REG_IDX_W-1:0] cfg_index = '0;
	logic [phcl_pkg::DATA_W-1:0]    cfg_wdata = '0;

	// lookup state as the unit should hold it
	logic [31:0] disp_mem [phcl_pkg::TABLE_DEPTH];
	logic [31:0] slot_mem [phcl_pkg::TABLE_DEPTH];
	logic [63:0] key_mem  [phcl_pkg::TABLE_DEPTH];
	logic [63:0] val_mem  [phcl_pkg::TABLE_DEPTH];
	bit   [3:0]  loaded   [phcl_pkg::TABLE_DEPTH];
	logic [8:0]  len_reg  = 9'd1;
	logic [63:0] dflt_reg = '0;

	phcl_pkg::result_t lookup_results_due [$];
	logic [63:0]       known_keys [$];
	phcl_pkg::result_t head;
	bit          failed         = 1'b0;
	int unsigned cycle_count    = 0;
	int unsigned accepted_items = 0;
	int unsigned src_idle_pct   = 6;
	int unsigned sink_idle_pct  = 77;

	int phase_len [N_PHASES] = '{0, 2, 5, 13, 40, 256, 511, 300, 1, 7};

	step_row_t directed_steps [N_DIRECTED] = '{
		'{phcl_pkg::CMD_WR_DISP,  8'd0,   ONES,  64'd0, 1'b0, phcl_pkg::ST_FOUND, 8'd0, 64'd0},
		'{phcl_pkg::CMD_WR_SLOT,  8'd0,   64'd0, ONES,  1'b0, phcl_pkg::ST_FOUND, 8'd0, 64'd0},
		'{phcl_pkg::CMD_WR_KEY,   8'd0,   MIN64, 64'd0, 1'b0, phcl_pkg::ST_FOUND, 8'd0, 64'd0},
		'{phcl_pkg::CMD_WR_VALUE, 8'd0,   MAX64, 64'd0, 1'b0, phcl_pkg::ST_FOUND, 8'd0, 64'd0},
		'{phcl_pkg::CMD_LOOKUP,   8'd0,   64'd0, MIN64, 1'b1, phcl_pkg::ST_FOUND, 8'd0, MAX64},
		'{phcl_pkg::CMD_LOOKUP,   8'd255, ONES,  MAX64, 1'b1, phcl_pkg::ST_MISMATCH, 8'd0,
			64'd0},
		// direct slot equal to the length
		'{phcl_pkg::CMD_WR_DISP,  8'd0,   64'h0000_0000_FFFF_FFFE, 64'd0, 1'b0,
			phcl_pkg::ST_FOUND, 8'd0, 64'd0},
		'{phcl_pkg::CMD_LOOKUP,   8'd0,   64'd0, MIN64, 1'b1, phcl_pkg::ST_RANGE, 8'd0, 64'd0},
		// zero seed, upper word bits ignored
		'{phcl_pkg::CMD_WR_DISP,  8'd0,   64'hFFFF_FFFF_0000_0000, 64'd0, 1'b0,
			phcl_pkg::ST_FOUND, 8'd0, 64'd0},
		'{phcl_pkg::CMD_LOOKUP,   8'd0,   64'd0, MIN64, 1'b1, phcl_pkg::ST_FOUND, 8'd0, MAX64},
		// negative slot entry, then one not below the length
		'{phcl_pkg::CMD_WR_SLOT,  8'd0,   64'h0000_0000_8000_0000, 64'd0, 1'b0,
			phcl_pkg::ST_FOUND, 8'd0, 64'd0},
		'{phcl_pkg::CMD_LOOKUP,   8'd0,   64'd0, MIN64, 1'b1, phcl_pkg::ST_RANGE, 8'd0, 64'd0},
		'{phcl_pkg::CMD_WR_SLOT,  8'd0,   64'd1, 64'd0, 1'b0, phcl_pkg::ST_FOUND, 8'd0, 64'd0},
		'{phcl_pkg::CMD_LOOKUP,   8'd0,   64'd0, MIN64, 1'b1, phcl_pkg::ST_RANGE, 8'd0, 64'd0},
		'{phcl_pkg::CMD_WR_SLOT,  8'd0,   64'hFFFF_FFFF_0000_0000, 64'd0, 1'b0,
			phcl_pkg::ST_FOUND, 8'd0, 64'd0},
		'{phcl_pkg::CMD_WR_DISP,  8'd0,   64'h0000_0000_7FFF_FFFF, 64'd0, 1'b0,
			phcl_pkg::ST_FOUND, 8'd0, 64'd0},
		'{phcl_pkg::CMD_LOOKUP,   8'd0,   64'd0, MIN64, 1'b1, phcl_pkg::ST_FOUND, 8'd0, MAX64},
		// spare commands are dropped
		'{CMD_SPARE_FIRST,        8'd255, ONES,  ONES,  1'b0, phcl_pkg::ST_FOUND, 8'd0, 64'd0},
		'{CMD_SPARE_FIRST + 3'd1, 8'd170, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
			1'b0, phcl_pkg::ST_FOUND, 8'd0, 64'd0},
		'{CMD_SPARE_LAST,         8'd85,  64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
			1'b0, phcl_pkg::ST_FOUND, 8'd0, 64'd0},
		'{phcl_pkg::CMD_WR_KEY,   8'd255, ONES,  64'd0, 1'b0, phcl_pkg::ST_FOUND, 8'd0, 64'd0},
		'{phcl_pkg::CMD_WR_VALUE, 8'd255, MIN64, 64'd0, 1'b0, phcl_pkg::ST_FOUND, 8'd0, 64'd0},
		'{phcl_pkg::CMD_WR_KEY,   8'd0,   ONES,  64'd0, 1'b0, phcl_pkg::ST_FOUND, 8'd0, 64'd0},
		'{phcl_pkg::CMD_WR_VALUE, 8'd0,   MIN64, 64'd0, 1'b0, phcl_pkg::ST_FOUND, 8'd0, 64'd0},
		'{phcl_pkg::CMD_LOOKUP,   8'd0,   64'd0, ONES,  1'b1, phcl_pkg::ST_FOUND, 8'd0, MIN64}
	};

	perfect_hash_category_lookup_unit i_dut (
		.clk,
		.arst_n,
		.item_valid,
		.item_ready,
		.item,
		.result_valid,
		.result_ready,
		.result,
		.cfg_we,
		.cfg_index,
		.cfg_wdata
	);

	always #4 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [31:0] fnv_fold(logic [31:0] seed, logic [63:0] key);
		logic [31:0] h;
		h = (seed == '0) ? phcl_pkg::FNV_PRIME : seed;
		for (int i = 0; i < phcl_pkg::KEY_BYTES; i++) begin
			h = h * phcl_pkg::FNV_PRIME;
			h = h ^ {{24{key[8*i+7]}}, key[8*i +: 8]};
		end
		return h;
	endfunction

	function automatic logic [31:0] eff_len();
		if (len_reg == '0) begin
			return 32'd1;
		end else if (len_reg > phcl_pkg::TABLE_DEPTH) begin
			return 32'(phcl_pkg::TABLE_DEPTH);
		end
		return 32'(len_reg);
	endfunction

	function automatic phcl_pkg::result_t predict_lookup(logic [63:0] key);
		logic [31:0] n, h, d, pick, v;
		phcl_pkg::result_t r;
		n = eff_len();
		h = fnv_fold('0, key) % n;
		d = disp_mem[h[7:0]];
		r.status       = phcl_pkg::ST_RANGE;
		r.slot_index   = '0;
		r.mapped_value = dflt_reg;
		if (d[31]) begin
			pick = ~d;
			if (pick >= n) begin
				return r;
			end
		end else begin
			pick = fnv_fold(d, key) % n;
		end
		v = slot_mem[pick[7:0]];
		if (v >= n) begin
			return r;
		end
		r.slot_index = v[7:0];
		if (key_mem[v[7:0]] == key) begin
			r.status       = phcl_pkg::ST_FOUND;
			r.mapped_value = val_mem[v[7:0]];
		end else begin
			r.status = phcl_pkg::ST_MISMATCH;
		end
		return r;
	endfunction

	function automatic phcl_pkg::item_t make_item(logic [2:0] cmd, logic [7:0] slot,
			logic [63:0] word);
		phcl_pkg::item_t it;
		it.cmd        = cmd;
		it.table_slot = slot;
		it.table_word = word;
		it.lookup_key = rand64();
		return it;
	endfunction

	function automatic phcl_pkg::item_t lookup_item(logic [63:0] key);
		phcl_pkg::item_t it;
		it = make_item(phcl_pkg::CMD_LOOKUP, 8'($urandom_range(255)), rand64());
		it.lookup_key = key;
		return it;
	endfunction

	// entry data: direct picks in and beyond range, rehash seeds, zero seed
	function automatic logic [63:0] entry_word(logic [2:0] tbl, logic [31:0] n);
		int unsigned r;
		logic [31:0] w;
		r = $urandom_range(99);
		case (tbl)
			phcl_pkg::CMD_WR_DISP: begin
				if (r < 40) w = ~32'($urandom_range(n - 1));
				else if (r < 55) w = $urandom | 32'h8000_0000;
				else if (r < 90) w = $urandom & 32'h7FFF_FFFF;
				else w = '0;
				return {$urandom, w};
			end
			phcl_pkg::CMD_WR_SLOT: begin
				if (r < 75) w = $urandom_range(n - 1);
				else if (r < 85) w = $urandom | 32'h8000_0000;
				else w = n + $urandom_range(300);
				return {$urandom, w};
			end
			default: return rand64();
		endcase
	endfunction

	task automatic send_item(input phcl_pkg::item_t it, input bit typed = 1'b0,
			input phcl_pkg::result_t want = '0);
		if ($urandom_range(99) < src_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		case (it.cmd)
			phcl_pkg::CMD_WR_DISP:  disp_mem[it.table_slot] = it.table_word[31:0];
			phcl_pkg::CMD_WR_SLOT:  slot_mem[it.table_slot] = it.table_word[31:0];
			phcl_pkg::CMD_WR_KEY:   key_mem[it.table_slot]  = it.table_word;
			phcl_pkg::CMD_WR_VALUE: val_mem[it.table_slot]  = it.table_word;
			phcl_pkg::CMD_LOOKUP:   lookup_results_due.insert(lookup_results_due.size(),
					typed ? want : predict_lookup(it.lookup_key));
			default: ;
		endcase
		if (it.cmd <= phcl_pkg::CMD_LOOKUP) begin
			accepted_items++;
		end
		if (it.cmd < phcl_pkg::CMD_LOOKUP) begin
			loaded[it.table_slot][it.cmd[1:0]] = 1'b1;
		end
	endtask

	// drop valid, let every lookup come back, then let trailing writes drain
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (lookup_results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [phcl_pkg::REG_IDX_W-1:0] idx,
			input logic [63:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == phcl_pkg::REG_TABLE_LEN) begin
			len_reg = val[8:0];
		end else begin
			dflt_reg = val;
		end
	endtask

	// route a fresh key to a chosen slot, store it, then look it up
	task automatic insert_and_lookup(input logic [31:0] n);
		logic [63:0] key;
		logic [31:0] h1, d, pick, v;
		key = rand64();
		h1  = fnv_fold('0, key) % n;
		if ($urandom_range(1) == 0) begin
			pick = $urandom_range(n - 1);
			d    = ~pick;
		end else begin
			d    = ($urandom_range(9) == 0) ? '0 : ($urandom & 32'h7FFF_FFFF);
			pick = fnv_fold(d, key) % n;
		end
		v = $urandom_range(n - 1);
		send_item(make_item(phcl_pkg::CMD_WR_DISP, h1[7:0], {$urandom, d}));
		send_item(make_item(phcl_pkg::CMD_WR_SLOT, pick[7:0], {$urandom, v}));
		send_item(make_item(phcl_pkg::CMD_WR_KEY, v[7:0], key));
		send_item(make_item(phcl_pkg::CMD_WR_VALUE, v[7:0], rand64()));
		send_item(lookup_item(key));
		known_keys.insert(known_keys.size(), key);
		if (known_keys.size() > 32) begin
			void'(known_keys.pop_front());
		end
	endtask

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (lookup_results_due.size() == 0) begin
				$error("result transfer with no lookup pending: status %0d slot %0d",
					result.status, result.slot_index);
				failed = 1'b1;
			end else begin
				head = lookup_results_due.pop_front();
				if (result.status !== head.status) begin
					$error("status: expected %0d, got %0d", head.status, result.status);
					failed = 1'b1;
				end
				if (result.slot_index !== head.slot_index) begin
					$error("slot_index: expected %0d, got %0d", head.slot_index,
						result.slot_index);
					failed = 1'b1;
				end
				if (result.mapped_value !== head.mapped_value) begin
					$error("mapped_value: expected %h, got %h", head.mapped_value,
						result.mapped_value);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("perfect_hash_category_lookup_unit_tb NOT OK");
			$finish;
		end
	end

	initial begin
		logic [31:0] n;
		logic [63:0] w;
		int unsigned start, r;
		logic [2:0]  c;
		step_row_t   row;
		phcl_pkg::result_t want;
		phcl_pkg::item_t   it;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: one entry in use, every key lands on it
		for (int i = 0; i < N_DIRECTED; i++) begin
			row = directed_steps[5'(i)];
			it.cmd        = row.cmd;
			it.table_slot = row.slot;
			it.table_word = row.word;
			it.lookup_key = row.key;
			want.status       = row.st;
			want.slot_index   = row.idx;
			want.mapped_value = row.val;
			send_item(it, row.typed, want);
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph < 4) begin
				src_idle_pct  = 6;
				sink_idle_pct = 77;
			end else if (ph < 7) begin
				src_idle_pct  = 77;
				sink_idle_pct = 6;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			settle();
			w      = rand64();
			w[8:0] = 9'(phase_len[4'(ph)]);
			write_reg(phcl_pkg::REG_TABLE_LEN, w);
			case (ph)
				0, 8:    w = MAX64;
				1, 6:    w = MIN64;
				9:       w = '0;
				default: w = rand64();
			endcase
			write_reg(phcl_pkg::REG_DEFAULT, w);
			n = eff_len();

			// load every entry a lookup can reach before the first lookup
			for (int i = 0; i < n; i++) begin
				for (int t = phcl_pkg::CMD_WR_DISP; t <= phcl_pkg::CMD_WR_VALUE; t++) begin
					if (!loaded[8'(i)][2'(t)]) begin
						send_item(make_item(3'(t), 8'(i), entry_word(3'(t), n)));
					end
				end
			end

			start = accepted_items;
			while (accepted_items - start < ITEMS_PER_PHASE) begin
				r = $urandom_range(99);
				if (r < 45) begin
					insert_and_lookup(n);
				end else if (r < 60 && known_keys.size() > 0) begin
					send_item(lookup_item(known_keys[$urandom_range(known_keys.size() - 1)]));
				end else if (r < 85) begin
					c = 3'($urandom_range(phcl_pkg::CMD_WR_DISP, phcl_pkg::CMD_WR_VALUE));
					send_item(make_item(c, 8'($urandom_range(255)), entry_word(c, n)));
				end else if (r < 95) begin
					send_item(lookup_item(rand64()));
				end else begin
					send_item(make_item(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
						8'($urandom_range(255)), rand64()));
				end
				if ($urandom_range(299) == 0) begin
					settle();
				end
			end
		end

		settle();
		if (!failed) begin
			$display("perfect_hash_category_lookup_unit_tb OK");
		end else begin
			$display("perfect_hash_category_lookup_unit_tb NOT OK");
		end
		$finish;
	end

endmodule
